// ----- rtl/core/lfbd_pkg.sv -----
package lfbd_pkg;

    localparam int WINDOW_SIZE     = 4096;
    localparam int ADDR_W          = $clog2(WINDOW_SIZE);
    localparam int BYTE_W          = 8;
    localparam int RAW_SIZE_W      = 24;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int LEN_W           = 5;
    localparam int FLAG_CNT_W      = 4;

    localparam logic [RAW_SIZE_W-1:0] RAW_SIZE_RESET = RAW_SIZE_W'(1);
    localparam logic [LEN_W-1:0]      MATCH_LEN_BIAS = LEN_W'(3);
    localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_BYTE = FLAG_CNT_W'(8);

    // one request to the history RAM per cycle: a write port and a read port
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } hist_req_t;

endpackage

// ----- rtl/core/lfbd_hist_ram.sv -----
module lfbd_hist_ram (
    input  logic                              aclk,
    input  lfbd_pkg::hist_req_t               req,
    output logic [lfbd_pkg::BYTE_W-1:0]       rd_data
);

    logic [lfbd_pkg::BYTE_W-1:0] mem [lfbd_pkg::WINDOW_SIZE];
    logic [lfbd_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        // data holds while no read is issued
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lzss_flag_byte_decompressor_unit.sv -----
// Channel   Direction  Ports                                         Handshake
// -------   ---------  --------------------------------------------  ------------------
// packed    in         s_packed_byte                                 s_valid / s_ready
// result    out        m_out_byte m_run_last m_stream_done m_error   m_valid / m_ready
// config    in         cfg_wr_data (raw_size)                        cfg_wr_en, no wait
//
// A flag byte, a first match byte or a literal is handled in ST_IDLE with no copy.
// A second match byte starts a copy: per copied byte a RAM read (ST_RD), then
// write-back and output (ST_WR); a match copies 3 to 18 bytes, but a clipped match
// may copy only one byte; the single-port-pair history RAM sets this.
// aresetn is synchronous, active low; the history RAM is not cleared, no sweep is run.
// s_ready drops while a copy runs and while the result register is full and not taken.
module lzss_flag_byte_decompressor_unit #(
    parameter int COUNT_BITS = lfbd_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lfbd_pkg::BYTE_W-1:0]         s_packed_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lfbd_pkg::BYTE_W-1:0]         m_out_byte,
    output logic                                m_run_last,
    output logic                                m_stream_done,
    output logic                                m_error,
    input  logic                                cfg_wr_en,
    input  logic [lfbd_pkg::RAW_SIZE_W-1:0]     cfg_wr_data
);

    localparam int AW    = lfbd_pkg::ADDR_W;
    localparam int BW    = lfbd_pkg::BYTE_W;
    localparam int LW    = lfbd_pkg::LEN_W;
    localparam int FW    = lfbd_pkg::FLAG_CNT_W;
    localparam int LIM_W = (COUNT_BITS > lfbd_pkg::RAW_SIZE_W) ? COUNT_BITS
                                                                : lfbd_pkg::RAW_SIZE_W;

    typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_WR} state_t;
    typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_HIGH, PH_LOW} phase_t;

    typedef struct packed {
        phase_t          phase;
        logic [BW-1:0]   bits;
        logic [FW-1:0]   left;
    } flag_adv_t;

    // pick the next phase from the flag byte, or ask for a new flag byte
    function automatic flag_adv_t next_flag(input logic [BW-1:0] bits,
                                            input logic [FW-1:0] left);
        flag_adv_t r;
        r.bits  = bits;
        r.left  = left;
        r.phase = PH_FLAG;
        if (left != '0) begin
            r.phase = bits[BW-1] ? PH_HIGH : PH_LIT;
            r.bits  = {bits[BW-2:0], 1'b0};
            r.left  = left - FW'(1);
        end
        return r;
    endfunction

    state_t                       st_reg, st_next;
    phase_t                       phase_reg, phase_next;
    logic [AW-1:0]                wp_reg, wp_next;
    logic [COUNT_BITS-1:0]        wc_reg, wc_next;
    logic [BW-1:0]                flag_bits_reg, flag_bits_next;
    logic [FW-1:0]                flags_left_reg, flags_left_next;
    logic [BW-1:0]                match_high_reg, match_high_next;
    logic                         halted_reg, halted_next;
    logic [lfbd_pkg::RAW_SIZE_W-1:0] raw_size_reg;
    logic [AW-1:0]                dist_reg, dist_next;
    logic [LW-1:0]                len_left_reg, len_left_next;

    logic                         m_valid_reg, m_valid_next;
    logic [BW-1:0]                m_byte_reg, m_byte_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_done_reg, m_done_next;
    logic                         m_err_reg, m_err_next;

    lfbd_pkg::hist_req_t          req;
    logic [BW-1:0]                rd_data;

    logic [LIM_W-1:0]             limit;
    logic [LIM_W-1:0]             wc_ext;
    logic [LIM_W-1:0]             owed;
    logic                         out_complete;
    logic                         done_after;
    logic                         slot_free;
    logic                         in_acc;
    logic [AW-1:0]                dist_in;
    logic [LW-1:0]                len_raw;
    logic                         bad_dist;
    flag_adv_t                    adv;

    lfbd_hist_ram u_hist (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_size_reg <= lfbd_pkg::RAW_SIZE_RESET;
        end else if (cfg_wr_en) begin
            raw_size_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        limit = LIM_W'(raw_size_reg);
        if (LIM_W'(raw_size_reg) > LIM_W'({COUNT_BITS{1'b1}})) begin
            limit = LIM_W'({COUNT_BITS{1'b1}});
        end
    end

    assign wc_ext       = LIM_W'(wc_reg);
    assign owed         = limit - wc_ext;
    assign out_complete = (wc_ext >= limit);
    assign done_after   = ((wc_ext + LIM_W'(1)) >= limit);
    assign slot_free    = !m_valid_reg || m_ready;
    assign s_ready      = (st_reg == ST_IDLE) && slot_free;
    assign in_acc       = s_valid && s_ready;
    assign dist_in      = {match_high_reg[BW-1:BW-4], s_packed_byte};
    assign len_raw      = LW'(match_high_reg[3:0]) + lfbd_pkg::MATCH_LEN_BIAS;
    assign bad_dist     = (dist_in == '0) || (COUNT_BITS'(dist_in) > wc_reg);
    assign adv          = next_flag(flag_bits_reg, flags_left_reg);

    always_comb begin
        st_next         = st_reg;
        phase_next      = phase_reg;
        wp_next         = wp_reg;
        wc_next         = wc_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        match_high_next = match_high_reg;
        halted_next     = halted_reg;
        dist_next       = dist_reg;
        len_left_next   = len_left_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_err_next      = m_err_reg;
        req.we          = 1'b0;
        req.wr_addr     = wp_reg;
        req.wr_data     = s_packed_byte;
        req.rd_en       = 1'b0;
        req.rd_addr     = wp_reg - dist_reg;

        case (st_reg)
            ST_IDLE: begin
                if (in_acc && !halted_reg) begin
                    if (out_complete) begin
                        halted_next = 1'b1;
                    end else begin
                        case (phase_reg)
                            PH_FLAG: begin
                                flag_bits_next  = {s_packed_byte[BW-2:0], 1'b0};
                                flags_left_next = lfbd_pkg::FLAGS_PER_BYTE - FW'(1);
                                phase_next      = s_packed_byte[BW-1] ? PH_HIGH : PH_LIT;
                            end
                            PH_LIT: begin
                                req.we       = 1'b1;
                                wp_next      = wp_reg + AW'(1);
                                wc_next      = wc_reg + COUNT_BITS'(1);
                                m_valid_next = 1'b1;
                                m_byte_next  = s_packed_byte;
                                m_last_next  = 1'b1;
                                m_done_next  = done_after;
                                m_err_next   = 1'b0;
                                if (done_after) begin
                                    halted_next = 1'b1;
                                end else begin
                                    phase_next      = adv.phase;
                                    flag_bits_next  = adv.bits;
                                    flags_left_next = adv.left;
                                end
                            end
                            PH_HIGH: begin
                                match_high_next = s_packed_byte;
                                phase_next      = PH_LOW;
                            end
                            PH_LOW: begin
                                if (bad_dist) begin
                                    halted_next  = 1'b1;
                                    m_valid_next = 1'b1;
                                    m_byte_next  = '0;
                                    m_last_next  = 1'b1;
                                    m_done_next  = 1'b0;
                                    m_err_next   = 1'b1;
                                end else begin
                                    dist_next     = dist_in;
                                    len_left_next = (LIM_W'(len_raw) > owed) ? LW'(owed)
                                                                            : len_raw;
                                    st_next       = ST_RD;
                                end
                            end
                            default: begin
                                phase_next = PH_FLAG;
                            end
                        endcase
                    end
                end
            end
            ST_RD: begin
                req.rd_en = 1'b1;
                st_next   = ST_WR;
            end
            ST_WR: begin
                // hold the fetched byte until the result register is free
                if (slot_free) begin
                    req.we        = 1'b1;
                    req.wr_data   = rd_data;
                    wp_next       = wp_reg + AW'(1);
                    wc_next       = wc_reg + COUNT_BITS'(1);
                    len_left_next = len_left_reg - LW'(1);
                    m_valid_next  = 1'b1;
                    m_byte_next   = rd_data;
                    m_err_next    = 1'b0;
                    m_last_next   = 1'b0;
                    m_done_next   = 1'b0;
                    if (len_left_reg == LW'(1)) begin
                        m_last_next = 1'b1;
                        m_done_next = done_after;
                        st_next     = ST_IDLE;
                        if (done_after) begin
                            halted_next = 1'b1;
                        end else begin
                            phase_next      = adv.phase;
                            flag_bits_next  = adv.bits;
                            flags_left_next = adv.left;
                        end
                    end else begin
                        st_next = ST_RD;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            phase_reg      <= PH_FLAG;
            wp_reg         <= '0;
            wc_reg         <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            match_high_reg <= '0;
            halted_reg     <= 1'b0;
            len_left_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            wp_reg         <= wp_next;
            wc_reg         <= wc_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            match_high_reg <= match_high_next;
            halted_reg     <= halted_next;
            len_left_reg   <= len_left_next;
            m_valid_reg    <= m_valid_next;
        end
        dist_reg   <= dist_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_done_reg <= m_done_next;
        m_err_reg  <= m_err_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_run_last    = m_last_reg;
    assign m_stream_done = m_done_reg;
    assign m_error       = m_err_reg;

    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == ST_WR |-> $past(st_reg) == ST_RD || $past(st_reg) == ST_WR)
        else $error("copy write-back without a preceding history read");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_no_rw_same: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.we && req.rd_en))
        else $error("history read and write in the same cycle");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg != ST_IDLE |-> !s_ready)
        else $error("input accepted during a copy");

    a_err_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> m_last_reg && !m_done_reg && m_byte_reg == '0)
        else $error("malformed error result");

endmodule
